// ===== rtl/etfi_pkg.sv =====
// ----------------------------------------------------------------------------
// etfi_pkg
// Shared constants, register indexes, mode codes and types of the
// escape-time iterator.
// ----------------------------------------------------------------------------
package etfi_pkg;

    localparam int COORD_BITS_DEF = 40;
    localparam int FRAC_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ITER_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_JULIA_MODE = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_JULIA_RE   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_JULIA_IM   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PRE_MAP    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POWER      = 3'd5;

    localparam logic [1:0] PRE_IDENT = 2'd0;
    localparam logic [1:0] PRE_CONJ  = 2'd1;
    localparam logic [1:0] PRE_ABS   = 2'd2;

    localparam logic [1:0] POW_SQUARE = 2'd0;
    localparam logic [1:0] POW_CUBE   = 2'd1;
    localparam logic [1:0] POW_IDENT  = 2'd2;

    localparam longint ITER_LIMIT_RST = 1000;
    localparam logic   JULIA_MODE_RST = 1'b1;
    localparam longint JULIA_RE_RST   = -64'sd3006477107;
    localparam longint JULIA_IM_RST   = 64'sd1160285415;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic int bytes_up(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

// ===== rtl/etfi_front.sv =====
// ----------------------------------------------------------------------------
// etfi_front
// Input side: takes a point beat and forms the start value and the additive
// constant according to the fractal mode, then pushes them to the queue.
// ----------------------------------------------------------------------------
module etfi_front #(
    parameter int W = etfi_pkg::COORD_BITS_DEF
) (
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic signed [W-1:0]   point_re,
    input  logic signed [W-1:0]   point_im,
    input  logic                  julia_mode,
    input  logic signed [W-1:0]   julia_const_re,
    input  logic signed [W-1:0]   julia_const_im,
    input  etfi_pkg::q_stat_t     q_stat,
    output logic                  push,
    output logic [4*W-1:0]        push_data   // zr, zi, cr, ci from the lowest bit up
);
    import etfi_pkg::*;

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

    always_comb begin
        if (julia_mode) begin
            push_data = {julia_const_im, julia_const_re, point_im, point_re};
        end else begin
            push_data = {point_im, point_re, {(2*W){1'b0}}};
        end
    end

endmodule

// ===== rtl/etfi_queue.sv =====
// ----------------------------------------------------------------------------
// etfi_queue
// Short FIFO between the front and the iterating back end.
// ----------------------------------------------------------------------------
module etfi_queue #(
    parameter int DW = 4 * etfi_pkg::COORD_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DW-1:0]     push_data,
    input  logic              pop,
    output logic [DW-1:0]     pop_data,
    output etfi_pkg::q_stat_t q_stat
);
    import etfi_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DW-1:0]    mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign q_stat.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/etfi_mul.sv =====
// ----------------------------------------------------------------------------
// etfi_mul
// Shared fixed-point multiplier: magnitude product built from four half-width
// partial products, one per cycle, then floor rounding and saturation.
// ----------------------------------------------------------------------------
module etfi_mul #(
    parameter int W = etfi_pkg::COORD_BITS_DEF,
    parameter int F = etfi_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic                  done,
    output logic signed [W-1:0]   fx,
    output logic [2*W-1:0]        prod
);
    import etfi_pkg::*;

    localparam int H   = (W + 1) / 2;
    localparam int PW  = 2 * W;
    localparam int QW  = PW - F;
    localparam int SHW = $clog2(2 * H + 1);

    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [QW:0] LIM_POS = (QW+1)'({(W-1){1'b1}});
    localparam logic [QW:0] LIM_NEG = LIM_POS + (QW+1)'(1);

    typedef enum logic [1:0] {M_IDLE, M_ACC, M_RND} mstate_t;

    mstate_t            state_reg;
    logic [1:0]         ph_reg;
    logic [W-1:0]       amag_reg;
    logic [W-1:0]       bmag_reg;
    logic               neg_reg;
    logic [PW-1:0]      acc_reg;
    logic signed [W-1:0] fx_reg;
    logic               done_reg;

    logic [W-1:0]       a_mag;
    logic [W-1:0]       b_mag;
    logic [H-1:0]       a_part;
    logic [H-1:0]       b_part;
    logic [2*H-1:0]     pp;
    logic [SHW-1:0]     sh;
    logic [PW-1:0]      pp_shift;
    logic [QW-1:0]      q;
    logic [QW:0]        q_ext;
    logic [QW:0]        qr;
    logic               rem;
    logic signed [W-1:0] fx_next;

    assign a_mag    = a[W-1] ? W'(-a) : W'(a);
    assign b_mag    = b[W-1] ? W'(-b) : W'(b);
    assign a_part   = ph_reg[0] ? H'(amag_reg[W-1:H]) : amag_reg[H-1:0];
    assign b_part   = ph_reg[1] ? H'(bmag_reg[W-1:H]) : bmag_reg[H-1:0];
    assign pp       = a_part * b_part;
    assign sh       = (ph_reg[0] ? SHW'(H) : SHW'(0)) + (ph_reg[1] ? SHW'(H) : SHW'(0));
    assign pp_shift = PW'(pp) << sh;

    assign q     = acc_reg[PW-1:F];
    assign rem   = |acc_reg[F-1:0];
    assign q_ext = {1'b0, q};
    assign qr    = q_ext + (QW+1)'(rem);

    always_comb begin
        if (!neg_reg) begin
            fx_next = (q_ext > LIM_POS) ? VMAX : $signed(q[W-1:0]);
        end else begin
            fx_next = (qr > LIM_NEG) ? VMIN : -$signed(qr[W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        amag_reg  <= a_mag;
                        bmag_reg  <= b_mag;
                        neg_reg   <= a[W-1] ^ b[W-1];
                        acc_reg   <= '0;
                        ph_reg    <= 2'd0;
                        state_reg <= M_ACC;
                    end
                end
                M_ACC: begin
                    acc_reg <= acc_reg + pp_shift;
                    ph_reg  <= ph_reg + 2'd1;
                    if (ph_reg == 2'd3) begin
                        state_reg <= M_RND;
                    end
                end
                M_RND: begin
                    fx_reg    <= fx_next;
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default: begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign fx   = fx_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/etfi_back.sv =====
// ----------------------------------------------------------------------------
// etfi_back
// Iteration sequencer: pre-map, square or cube power through the shared
// multiplier, add c, exact squared-magnitude escape test, result register.
// ----------------------------------------------------------------------------
module etfi_back #(
    parameter int W = etfi_pkg::COORD_BITS_DEF,
    parameter int F = etfi_pkg::FRAC_BITS_DEF,
    parameter int C = etfi_pkg::COUNT_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  etfi_pkg::q_stat_t q_stat,
    input  logic [4*W-1:0]    q_data,     // zr, zi, cr, ci from the lowest bit up
    output logic              pop,
    input  logic [C-1:0]      iteration_limit,
    input  logic [1:0]        pre_map_mode,
    input  logic [1:0]        power_mode,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [C-1:0]      escape_count
);
    import etfi_pkg::*;

    localparam int PW = 2 * W;
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [PW:0] ESC_LIMIT = (PW+1)'(1) << (2 * F + 2);

    localparam logic [3:0] OP_XX  = 4'd0;
    localparam logic [3:0] OP_YY  = 4'd1;
    localparam logic [3:0] OP_XY  = 4'd2;
    localparam logic [3:0] OP_RX  = 4'd3;
    localparam logic [3:0] OP_IY  = 4'd4;
    localparam logic [3:0] OP_RY  = 4'd5;
    localparam logic [3:0] OP_IX  = 4'd6;
    localparam logic [3:0] OP_ZR2 = 4'd7;
    localparam logic [3:0] OP_ZI2 = 4'd8;

    typedef enum logic [3:0] {
        B_IDLE, B_PRE, B_MUL, B_SQ, B_CUBE, B_ADD, B_CHK, B_TEST, B_DONE
    } bstate_t;

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] x,
                                                    input logic signed [W-1:0] y);
        logic [W:0] s;
        s = {x[W-1], x} + {y[W-1], y};
        if (s[W] != s[W-1]) begin
            return s[W] ? VMIN : VMAX;
        end
        return $signed(s[W-1:0]);
    endfunction

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] x,
                                                    input logic signed [W-1:0] y);
        logic [W:0] s;
        s = {x[W-1], x} - {y[W-1], y};
        if (s[W] != s[W-1]) begin
            return s[W] ? VMIN : VMAX;
        end
        return $signed(s[W-1:0]);
    endfunction

    function automatic logic signed [W-1:0] sat_neg(input logic signed [W-1:0] x);
        return (x == VMIN) ? VMAX : -x;
    endfunction

    bstate_t             state_reg;
    logic [3:0]          op_reg;
    logic                issued_reg;
    logic signed [W-1:0] zr_reg, zi_reg, cr_reg, ci_reg;
    logic signed [W-1:0] x_reg, y_reg, wr_reg, wi_reg;
    logic signed [W-1:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic [PW-1:0]       sq_re_reg, sq_im_reg;
    logic [C-1:0]        count_reg;
    logic [C-1:0]        result_reg;
    logic                m_valid_reg;
    logic [C-1:0]        m_count_reg;

    logic signed [W-1:0] px, py;
    logic signed [W-1:0] mul_a, mul_b;
    logic                mul_start;
    logic                mul_done;
    logic signed [W-1:0] mul_fx;
    logic [PW-1:0]       mul_prod;
    logic [PW:0]         mag_sum;
    logic                escaped;
    logic                more_steps;
    logic                out_load;

    always_comb begin
        px = zr_reg;
        py = zi_reg;
        case (pre_map_mode)
            PRE_IDENT: begin
                px = zr_reg;
                py = zi_reg;
            end
            PRE_CONJ: begin
                py = sat_neg(zi_reg);
            end
            PRE_ABS: begin
                if (zr_reg[W-1]) px = sat_neg(zr_reg);
                if (zi_reg[W-1]) py = sat_neg(zi_reg);
            end
            default: begin
                px = zr_reg;
                py = zi_reg;
            end
        endcase
    end

    always_comb begin
        case (op_reg)
            OP_XX:   begin mul_a = x_reg;  mul_b = x_reg; end
            OP_YY:   begin mul_a = y_reg;  mul_b = y_reg; end
            OP_XY:   begin mul_a = x_reg;  mul_b = y_reg; end
            OP_RX:   begin mul_a = wr_reg; mul_b = x_reg; end
            OP_IY:   begin mul_a = wi_reg; mul_b = y_reg; end
            OP_RY:   begin mul_a = wr_reg; mul_b = y_reg; end
            OP_IX:   begin mul_a = wi_reg; mul_b = x_reg; end
            OP_ZR2:  begin mul_a = zr_reg; mul_b = zr_reg; end
            OP_ZI2:  begin mul_a = zi_reg; mul_b = zi_reg; end
            default: begin mul_a = zi_reg; mul_b = zi_reg; end
        endcase
    end

    assign mul_start  = (state_reg == B_MUL) && !issued_reg;
    assign mag_sum    = (PW+1)'(sq_re_reg) + (PW+1)'(sq_im_reg);
    assign escaped    = mag_sum > ESC_LIMIT;
    assign more_steps = ((C+1)'(count_reg) + (C+1)'(1)) < (C+1)'(iteration_limit);
    assign pop        = (state_reg == B_IDLE) && !q_stat.empty;
    assign out_load   = (state_reg == B_DONE) && (!m_valid_reg || m_tready);

    etfi_mul #(
        .W (W),
        .F (F)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .fx      (mul_fx),
        .prod    (mul_prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (!q_stat.empty) begin
                        zr_reg    <= $signed(q_data[W-1:0]);
                        zi_reg    <= $signed(q_data[2*W-1:W]);
                        cr_reg    <= $signed(q_data[3*W-1:2*W]);
                        ci_reg    <= $signed(q_data[4*W-1:3*W]);
                        count_reg <= '0;
                        state_reg <= B_PRE;
                    end
                end
                B_PRE: begin
                    x_reg <= px;
                    y_reg <= py;
                    if (power_mode == POW_SQUARE || power_mode == POW_CUBE) begin
                        op_reg    <= OP_XX;
                        state_reg <= B_MUL;
                    end else begin
                        wr_reg    <= px;
                        wi_reg    <= py;
                        state_reg <= B_ADD;
                    end
                end
                B_MUL: begin
                    if (!issued_reg) begin
                        issued_reg <= 1'b1;
                    end else if (mul_done) begin
                        issued_reg <= 1'b0;
                        op_reg     <= op_reg + 4'd1;
                        case (op_reg)
                            OP_XX:  t0_reg <= mul_fx;
                            OP_YY:  t1_reg <= mul_fx;
                            OP_XY: begin
                                t2_reg    <= mul_fx;
                                state_reg <= B_SQ;
                            end
                            OP_RX:  t0_reg <= mul_fx;
                            OP_IY:  t1_reg <= mul_fx;
                            OP_RY:  t2_reg <= mul_fx;
                            OP_IX: begin
                                t3_reg    <= mul_fx;
                                state_reg <= B_CUBE;
                            end
                            OP_ZR2: sq_re_reg <= mul_prod;
                            OP_ZI2: begin
                                sq_im_reg <= mul_prod;
                                state_reg <= B_TEST;
                            end
                            default: state_reg <= B_IDLE;
                        endcase
                    end
                end
                B_SQ: begin
                    wr_reg <= sat_sub(t0_reg, t1_reg);
                    wi_reg <= sat_add(t2_reg, t2_reg);
                    if (power_mode == POW_CUBE) begin
                        op_reg    <= OP_RX;
                        state_reg <= B_MUL;
                    end else begin
                        state_reg <= B_ADD;
                    end
                end
                B_CUBE: begin
                    wr_reg    <= sat_sub(t0_reg, t1_reg);
                    wi_reg    <= sat_add(t2_reg, t3_reg);
                    state_reg <= B_ADD;
                end
                B_ADD: begin
                    zr_reg <= sat_add(wr_reg, cr_reg);
                    zi_reg <= sat_add(wi_reg, ci_reg);
                    if (count_reg == '0) begin
                        // first iterate is never tested
                        count_reg <= C'(1);
                        state_reg <= B_CHK;
                    end else begin
                        op_reg    <= OP_ZR2;
                        state_reg <= B_MUL;
                    end
                end
                B_CHK: begin
                    if (more_steps) begin
                        state_reg <= B_PRE;
                    end else begin
                        result_reg <= '0;
                        state_reg  <= B_DONE;
                    end
                end
                B_TEST: begin
                    if (escaped) begin
                        result_reg <= count_reg;
                        state_reg  <= B_DONE;
                    end else begin
                        count_reg <= count_reg + C'(1);
                        state_reg <= B_CHK;
                    end
                end
                B_DONE: begin
                    if (out_load) begin
                        m_count_reg <= result_reg;
                        state_reg   <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign escape_count = m_count_reg;

endmodule

// ===== rtl/escape_time_fractal_iterator.sv =====
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator
// Escape-time count of a complex point for Julia or Mandelbrot iteration with
// selectable pre-map and power, in saturating signed fixed point.
//
//   channel   direction  tdata (lowest bit up)          tuser/tlast
//   s_        in         point_re, point_im             -
//   m_        out        escape_count                   -
//   cfg_      in         write enable, index, data      -
//
// A multiply on the shared unit runs four partial products, rounding and
// hand-back. Square and cube steps use the shared unit, an identity step
// does not; each tested step also runs the magnitude test on it. Two points
// can wait in the queue while one iterates and a result waits in the output
// register. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator #(
    parameter int COORD_BITS = etfi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = etfi_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = etfi_pkg::COUNT_BITS_DEF
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    input  logic [etfi_pkg::bytes_up(2*COORD_BITS)-1:0]    s_tdata,  // point_re, point_im
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    output logic [etfi_pkg::bytes_up(COUNT_BITS)-1:0]      m_tdata,  // escape_count
    input  logic                                           cfg_wr_en,
    input  logic [etfi_pkg::CFG_INDEX_BITS-1:0]            cfg_index,
    input  logic [((COORD_BITS > COUNT_BITS) ? COORD_BITS : COUNT_BITS)-1:0] cfg_wdata
);
    import etfi_pkg::*;

    localparam int W   = COORD_BITS;
    localparam int MDW = bytes_up(COUNT_BITS);

    logic [COUNT_BITS-1:0] iter_limit_reg;
    logic                  julia_mode_reg;
    logic signed [W-1:0]   julia_re_reg;
    logic signed [W-1:0]   julia_im_reg;
    logic [1:0]            pre_map_reg;
    logic [1:0]            power_reg;

    logic signed [W-1:0]   point_re;
    logic signed [W-1:0]   point_im;
    q_stat_t               q_stat;
    logic                  push;
    logic [4*W-1:0]        push_data;
    logic                  pop;
    logic [4*W-1:0]        pop_data;
    logic [COUNT_BITS-1:0] escape_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_limit_reg <= COUNT_BITS'(ITER_LIMIT_RST);
            julia_mode_reg <= JULIA_MODE_RST;
            julia_re_reg   <= W'(JULIA_RE_RST);
            julia_im_reg   <= W'(JULIA_IM_RST);
            pre_map_reg    <= PRE_IDENT;
            power_reg      <= POW_SQUARE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ITER_LIMIT: iter_limit_reg <= cfg_wdata[COUNT_BITS-1:0];
                REG_JULIA_MODE: julia_mode_reg <= cfg_wdata[0];
                REG_JULIA_RE:   julia_re_reg   <= $signed(cfg_wdata[W-1:0]);
                REG_JULIA_IM:   julia_im_reg   <= $signed(cfg_wdata[W-1:0]);
                REG_PRE_MAP:    pre_map_reg    <= cfg_wdata[1:0];
                REG_POWER:      power_reg      <= cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    assign point_re = $signed(s_tdata[W-1:0]);
    assign point_im = $signed(s_tdata[2*W-1:W]);

    etfi_front #(
        .W (W)
    ) u_front (
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .point_re       (point_re),
        .point_im       (point_im),
        .julia_mode     (julia_mode_reg),
        .julia_const_re (julia_re_reg),
        .julia_const_im (julia_im_reg),
        .q_stat         (q_stat),
        .push           (push),
        .push_data      (push_data)
    );

    etfi_queue #(
        .DW (4 * W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    etfi_back #(
        .W (W),
        .F (FRAC_BITS),
        .C (COUNT_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_stat          (q_stat),
        .q_data          (pop_data),
        .pop             (pop),
        .iteration_limit (iter_limit_reg),
        .pre_map_mode    (pre_map_reg),
        .power_mode      (power_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .escape_count    (escape_count)
    );

    assign m_tdata = MDW'(escape_count);

endmodule

// ===== rtl/etfi_checker.sv =====
// ----------------------------------------------------------------------------
// etfi_checker
// Port-level checks of the escape-time iterator, bound to the top level.
// ----------------------------------------------------------------------------
module etfi_checker #(
    parameter int COUNT_BITS = etfi_pkg::COUNT_BITS_DEF
) (
    input logic                                       aclk,
    input logic                                       aresetn,
    input logic                                       s_tready,
    input logic                                       m_tvalid,
    input logic                                       m_tready,
    input logic [etfi_pkg::bytes_up(COUNT_BITS)-1:0]  m_tdata
);
    import etfi_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_CEIL = {{(COUNT_BITS-1){1'b1}}, 1'b0};

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // count never reaches the top two codes
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[COUNT_BITS-1:0] < COUNT_CEIL)
        else $error("escape count out of range");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat shown after reset");

endmodule

bind escape_time_fractal_iterator etfi_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_checker (.*);

// ===== verif/tb_escape_time_fractal_iterator.sv =====
// ----------------------------------------------------------------------------
// tb_escape_time_fractal_iterator
// Self-checking bench for the escape-time iterator. A bit-accurate predictor
// of the saturating fixed-point orbit computes the escape count of every
// accepted point. Each result beat is compared with the oldest predicted
// count. Directed tests cover the reset setup, saturation, every pre-map and
// power mode, and the iteration limit edges. Random traffic then runs under
// several idle and stall patterns on both stream sides.
// ----------------------------------------------------------------------------
module tb_escape_time_fractal_iterator;
    import etfi_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int NB = COUNT_BITS_DEF;
    localparam int CFG_W = (CB > NB) ? CB : NB;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT = 8_000_000;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_HI = 3'd7;
    localparam logic [1:0] PRE_UNUSED = 2'd3;
    localparam logic [1:0] POW_UNUSED = 2'd3;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [127:0] wide_t;
    typedef struct {
        coord_t re;
        coord_t im;
    } cplx_t;

    localparam coord_t Q_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam coord_t Q_MIN = {1'b1, {(CB-1){1'b0}}};
    localparam wide_t W_MAX = Q_MAX;
    localparam wide_t W_MIN = Q_MIN;
    localparam wide_t ESCAPE_BOUND = 128'sd1 <<< (2*FB + 2);

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [bytes_up(2*CB)-1:0]       s_tdata = '0;   // point_re, point_im
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [bytes_up(NB)-1:0]         m_tdata;        // escape_count
    logic                            cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]                cfg_wdata = '0;

    // shadow of the register file
    logic [NB-1:0] limit_r = NB'(ITER_LIMIT_RST);
    logic          julia_r = JULIA_MODE_RST;
    coord_t        c_re_r = coord_t'(JULIA_RE_RST);
    coord_t        c_im_r = coord_t'(JULIA_IM_RST);
    logic [1:0]    pre_map_r = PRE_IDENT;
    logic [1:0]    power_r = POW_SQUARE;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    logic [NB-1:0] expected_counts[$];

    escape_time_fractal_iterator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------- fixed-point predictor ----------------

    function automatic coord_t clamp_w(input wide_t v);
        if (v > W_MAX) return Q_MAX;
        if (v < W_MIN) return Q_MIN;
        return v[CB-1:0];
    endfunction

    // floor rounding comes from the arithmetic shift
    function automatic coord_t fx_product(input coord_t a, input coord_t b);
        wide_t wa, wb;
        wa = a;
        wb = b;
        return clamp_w((wa * wb) >>> FB);
    endfunction

    function automatic coord_t fx_sum(input coord_t a, input coord_t b);
        wide_t wa, wb;
        wa = a;
        wb = b;
        return clamp_w(wa + wb);
    endfunction

    function automatic coord_t fx_diff(input coord_t a, input coord_t b);
        wide_t wa, wb;
        wa = a;
        wb = b;
        return clamp_w(wa - wb);
    endfunction

    function automatic coord_t fx_negate(input coord_t a);
        wide_t wa;
        wa = a;
        return clamp_w(-wa);
    endfunction

    function automatic cplx_t next_orbit(input cplx_t z, input cplx_t c);
        coord_t x, y, wr, wi, xy, nr, ni;
        cplx_t  n;
        x = z.re;
        y = z.im;
        case (pre_map_r)
            PRE_CONJ: y = fx_negate(y);
            PRE_ABS: begin
                if (x < 0) x = fx_negate(x);
                if (y < 0) y = fx_negate(y);
            end
            default: ;
        endcase
        if (power_r == POW_SQUARE || power_r == POW_CUBE) begin
            xy = fx_product(x, y);
            wr = fx_diff(fx_product(x, x), fx_product(y, y));
            wi = fx_sum(xy, xy);
            if (power_r == POW_CUBE) begin
                nr = fx_diff(fx_product(wr, x), fx_product(wi, y));
                ni = fx_sum(fx_product(wr, y), fx_product(wi, x));
                wr = nr;
                wi = ni;
            end
        end else begin
            wr = x;
            wi = y;
        end
        n.re = fx_sum(wr, c.re);
        n.im = fx_sum(wi, c.im);
        return n;
    endfunction

    function automatic bit outside_radius(input cplx_t z);
        wide_t r, i;
        r = z.re;
        i = z.im;
        return (r * r + i * i) > ESCAPE_BOUND;
    endfunction

    function automatic logic [NB-1:0] escape_step(input coord_t p_re, input coord_t p_im);
        cplx_t z, c;
        int unsigned n;
        if (julia_r) begin
            z.re = p_re;
            z.im = p_im;
            c.re = c_re_r;
            c.im = c_im_r;
        end else begin
            z.re = '0;
            z.im = '0;
            c.re = p_re;
            c.im = p_im;
        end
        z = next_orbit(z, c);   // first iterate is never tested
        for (n = 1; n + 1 < limit_r; n++) begin
            z = next_orbit(z, c);
            if (outside_radius(z)) return n[NB-1:0];
        end
        return '0;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic coord_t to_fixed(input real x);
        longint v;
        v = longint'(x * (2.0 ** FB));
        return v[CB-1:0];
    endfunction

    // real c for the identity map whose orbit n*c crosses radius 2 right at,
    // or just past, the last tested step
    function automatic coord_t ramp_step(input int lim, input bit over);
        longint span;
        span = (longint'(1) <<< (FB + 1)) / (lim - 1);
        span = over ? span + 1 : span - 1;
        return span[CB-1:0];
    endfunction

    function automatic coord_t random_coord();
        coord_t v;
        int     kind;
        kind = $urandom_range(99);
        v = coord_t'({$urandom, $urandom});
        if (kind < 70) begin
            v = v >>> $urandom_range(CB - FB - 2, CB - FB + 1);
        end else if (kind >= 85) begin
            case ($urandom_range(4))
                0: v = Q_MIN;
                1: v = Q_MAX;
                2: v = '0;
                3: v = '1;
                default: v = coord_t'(1);
            endcase
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40) $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_ITER_LIMIT: limit_r = data[NB-1:0];
            REG_JULIA_MODE: julia_r = data[0];
            REG_JULIA_RE:   c_re_r = data[CB-1:0];
            REG_JULIA_IM:   c_im_r = data[CB-1:0];
            REG_PRE_MAP:    pre_map_r = data[1:0];
            REG_POWER:      power_r = data[1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [NB-1:0] limit, input logic julia,
                             input coord_t cre, input coord_t cim,
                             input logic [1:0] pre, input logic [1:0] pow);
        drain();
        write_reg(REG_ITER_LIMIT, CFG_W'(limit));
        write_reg(REG_JULIA_MODE, CFG_W'(julia));
        write_reg(REG_JULIA_RE, cre);
        write_reg(REG_JULIA_IM, cim);
        write_reg(REG_PRE_MAP, CFG_W'(pre));
        write_reg(REG_POWER, CFG_W'(pow));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_point(input coord_t p_re, input coord_t p_im);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {p_im, p_re};
        do @(posedge aclk); while (!s_tready);
        expected_counts.insert(expected_counts.size(), escape_step(p_re, p_im));
    endtask

    // ---------------- result checking ----------------

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_counts.size() == 0) begin
                report_mismatch("result beat with no point outstanding");
            end else begin
                if (m_tdata[NB-1:0] !== expected_counts[0])
                    report_mismatch($sformatf("escape_count %0d, expected %0d",
                                              m_tdata[NB-1:0], expected_counts[0]));
                expected_counts.delete(0);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------- tests ----------------

    task automatic test_reset_values();
        send_point('0, '0);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN);
        send_point(Q_MIN, Q_MAX);
        drain();
    endtask

    // negating the most negative value must clamp to the maximum
    task automatic test_saturation();
        configure(NB'(10), 1'b1, '0, '0, PRE_CONJ, POW_IDENT);
        send_point('0, Q_MIN);
        configure(NB'(10), 1'b1, '0, '0, PRE_ABS, POW_CUBE);
        send_point(Q_MIN, Q_MIN);
        send_point(Q_MIN, coord_t'(1));
        drain();
    endtask

    task automatic mode_pair(input logic julia, input logic [1:0] pre, input logic [1:0] pow);
        configure(NB'(24), julia, to_fixed(-0.4), to_fixed(0.6), pre, pow);
        send_point(to_fixed(-0.75), to_fixed(0.1));
        send_point(to_fixed(0.3), to_fixed(-0.5));
    endtask

    task automatic test_modes();
        mode_pair(1'b0, PRE_IDENT, POW_CUBE);
        mode_pair(1'b1, PRE_CONJ, POW_IDENT);
        mode_pair(1'b0, PRE_ABS, POW_UNUSED);
        mode_pair(1'b1, PRE_UNUSED, POW_SQUARE);
        drain();
    endtask

    task automatic test_limits();
        // junk above each register width must be dropped
        drain();
        write_reg(REG_ITER_LIMIT, 40'hFF_FFFF_000C);
        write_reg(REG_JULIA_MODE, 40'hFF_FFFF_FFFE);
        write_reg(REG_JULIA_RE, Q_MAX);
        write_reg(REG_JULIA_IM, Q_MIN);
        write_reg(REG_PRE_MAP, 40'hFF_FFFF_FFFC);
        write_reg(REG_POWER, 40'hFF_FFFF_FFFE);
        write_reg(REG_UNMAPPED_LO, '1);
        write_reg(REG_UNMAPPED_HI, 40'h55_5555_5555);
        cfg_wr_en <= 1'b0;
        send_point(ramp_step(12, 1'b1), '0);
        // limit too small to test any step
        configure(NB'(2), 1'b0, '0, '0, PRE_IDENT, POW_SQUARE);
        send_point(Q_MAX, Q_MAX);
        configure('1, 1'b0, '0, '0, PRE_IDENT, POW_SQUARE);
        send_point(Q_MAX, '0);
        configure(NB'(1000), 1'b0, '0, '0, PRE_IDENT, POW_IDENT);
        send_point(ramp_step(1000, 1'b0), '0);
        send_point(ramp_step(1000, 1'b1), '0);
        drain();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int seg, k;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (seg = 0; seg < 3; seg++) begin
            configure(NB'($urandom_range(10, 32)), 1'($urandom_range(1)),
                      random_coord(), random_coord(),
                      2'($urandom_range(PRE_UNUSED)), 2'($urandom_range(POW_UNUSED)));
            for (k = 0; k < 50; k++) begin
                if (seg == 1 && k == 25) drain();   // hold the sender until empty
                send_point(random_coord(), random_coord());
            end
        end
        drain();
    endtask

    initial begin : watchdog
        int cyc;
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge aclk);
        $display("[escape_time_fractal_iterator] ERROR");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_saturation();
        test_modes();
        test_limits();
        test_random_traffic(0, 0);
        test_random_traffic(67, 0);
        test_random_traffic(0, 67);
        test_random_traffic(14, 14);
        drain();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && expected_counts.size() == 0) begin
            $display("[escape_time_fractal_iterator] OK");
        end else begin
            $display("[escape_time_fractal_iterator] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/etfi_pkg.sv
rtl/etfi_front.sv
rtl/etfi_queue.sv
rtl/etfi_mul.sv
rtl/etfi_back.sv
rtl/escape_time_fractal_iterator.sv
rtl/etfi_checker.sv
verif/tb_escape_time_fractal_iterator.sv
